/* src/jafd_pkg.sv */
// Shared constants, register codes and divider interface types for the joystick axis filter.
`default_nettype none

package jafd_pkg;

   // Field and state widths
   localparam int SampleWidth   = 12;
   localparam int FracBits      = 8;
   localparam int StateWidth    = SampleWidth + FracBits;
   localparam int AlphaWidth    = 9;
   localparam int DeadzoneWidth = 11;
   localparam int PosWidth      = 9;
   localparam int CsrIndexWidth = 2;

   // Serial divider widths
   localparam int QuotWidth     = 8;
   localparam int CountWidth    = $clog2(QuotWidth);
   localparam int NumWidth      = 19;
   localparam int DivisorWidth  = 12;
   localparam int RemWidth      = DivisorWidth + QuotWidth;

   // Fixed levels
   localparam logic [AlphaWidth-1:0]    AlphaOne      = 9'd256;
   localparam logic [AlphaWidth-1:0]    AlphaReset    = 9'd64;
   localparam logic [DeadzoneWidth-1:0] DeadzoneReset = 11'd100;
   localparam logic [SampleWidth-1:0]   MidLevel      = 12'd2048;
   localparam logic [SampleWidth:0]     FullScale     = 13'd4096;
   localparam logic signed [PosWidth-1:0] MaxOut      = 9'sd255;

   // Configuration register indexes
   localparam logic [CsrIndexWidth-1:0] CsrAlpha  = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrCenter = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrEnd    = 2'd2;

   // Divider request and response
   typedef struct packed {
      logic                    start;
      logic [NumWidth-1:0]     dividend;
      logic [DivisorWidth-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [QuotWidth-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

/* src/jafd_div.sv */
// Restoring serial divider, one quotient bit per cycle, for an eight-bit quotient.
`default_nettype none

module jafd_div (
   input  wire                  clock,
   input  wire                  reset,
   input  wire jafd_pkg::div_req_type div_req,
   output jafd_pkg::div_rsp_type div_rsp
);
   import jafd_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [RemWidth-1:0]   rem_ff, rem_in;
   logic [RemWidth-1:0]   dsh_ff, dsh_in;
   logic [QuotWidth-1:0]  quot_ff, quot_in;
   logic                  fits;

   // Trial subtract against the shifted divisor
   assign fits = rem_ff >= dsh_ff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      quot_in  = quot_ff;
      if (div_req.start) begin
         // Load dividend and divisor aligned to the top quotient bit
         busy_in  = 1'b1;
         count_in = CountWidth'(QuotWidth - 1);
         rem_in   = {1'b0, div_req.dividend};
         dsh_in   = {1'b0, div_req.divisor, {(QuotWidth - 1){1'b0}}};
      end else if (busy_ff) begin
         // Advance one quotient bit
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         quot_in = {quot_ff[QuotWidth-2:0], fits};
         dsh_in  = {1'b0, dsh_ff[RemWidth-1:1]};
         count_in = count_ff - CountWidth'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      quot_ff  <= quot_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

`default_nettype wire

/* src/joystick_axis_filter_deadzone_unit.sv */
// Top level: EMA smoothing, deadzone mapping and sequencer around the serial divider.
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | req_adc_sample[11:0]
//  rsp     | out       | rsp_valid/stall   | rsp_axis_position[8:0] s, rsp_smoothed_level[11:0]
//  csr     | in        | csr_wr_en         | csr_index[1:0], csr_wdata[10:0]
//
// For a deadzone or clamp the result goes through multiply, accumulate, compare and output
// load; when scaled, the divider steps through each quotient bit and signals done before the load.
// Reset restores alpha 64, both deadzones 100 and a filter state of zero.
// req_stall stays high while an item is in work; a stalled result holds in the output
// register, and the next item may be accepted but waits in its last step until it frees.
`default_nettype none

module joystick_axis_filter_deadzone_unit (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [jafd_pkg::SampleWidth-1:0]      req_adc_sample,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic signed [jafd_pkg::PosWidth-1:0]  rsp_axis_position,
   output logic [jafd_pkg::SampleWidth-1:0]      rsp_smoothed_level,
   input  wire                                   csr_wr_en,
   input  wire  [jafd_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire  [jafd_pkg::DeadzoneWidth-1:0]    csr_wdata
);
   import jafd_pkg::*;

   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StMul  = 3'd1;
   localparam logic [2:0] StAcc  = 3'd2;
   localparam logic [2:0] StMap  = 3'd3;
   localparam logic [2:0] StDiv  = 3'd4;
   localparam logic [2:0] StOut  = 3'd5;

   localparam int ProdWidth = StateWidth + AlphaWidth + 2;

   logic [2:0]                  state_ff, state_in;
   logic [AlphaWidth-1:0]       alpha_ff, alpha_in;
   logic [DeadzoneWidth-1:0]    center_ff, center_in;
   logic [DeadzoneWidth-1:0]    end_ff, end_in;
   logic [StateWidth-1:0]       filt_ff, filt_in;
   logic [SampleWidth-1:0]      sample_ff, sample_in;
   logic signed [ProdWidth-1:0] prod_ff, prod_in;
   logic                        positive_ff, positive_in;
   logic signed [PosWidth-1:0]  pos_ff, pos_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [PosWidth-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [SampleWidth-1:0]      rsp_level_ff, rsp_level_in;

   logic [AlphaWidth-1:0]       alpha_sat;
   logic signed [StateWidth:0]  diff;
   logic signed [ProdWidth-1:0] acc;
   logic [SampleWidth-1:0]      level;
   logic                        positive;
   logic [SampleWidth-1:0]      mag;
   logic                        in_center;
   logic                        in_low_end;
   logic                        in_high_end;
   logic [SampleWidth-1:0]      excess;
   logic [RemWidth-1:0]         num_full;
   logic [DivisorWidth-1:0]     divisor;
   logic                        clamp;
   logic signed [PosWidth-1:0]  quot_pos;
   logic                        req_xfer;
   logic                        rsp_free;
   div_req_type                 div_req;
   div_rsp_type                 div_rsp;

   assign req_xfer = req_valid && (state_ff == StIdle);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Filter: new = f + a * (s - f), f and s in 12.8, a in 1.8 (256 = one), multiply registered before the add
   assign alpha_sat = (alpha_ff > AlphaOne) ? AlphaOne : alpha_ff;
   assign diff      = $signed({1'b0, sample_ff, {FracBits{1'b0}}}) - $signed({1'b0, filt_ff});
   assign prod_in   = $signed(ProdWidth'(diff)) * $signed(ProdWidth'({1'b0, alpha_sat}));
   assign acc       = $signed({{(ProdWidth - StateWidth - FracBits){1'b0}}, filt_ff,
                                {FracBits{1'b0}}}) + prod_ff;

   // Mapping compares on the integer level
   assign level       = filt_ff[StateWidth-1:FracBits];
   assign positive    = level >= MidLevel;
   assign mag         = positive ? (level - MidLevel) : (MidLevel - level);
   assign in_center   = mag <= {1'b0, center_ff};
   assign in_low_end  = level <= {1'b0, end_ff};
   assign in_high_end = {1'b0, level} >= (FullScale - {2'b0, end_ff});
   assign excess      = mag - {1'b0, center_ff};
   assign num_full    = {excess, {QuotWidth{1'b0}}} - {{QuotWidth{1'b0}}, excess};
   assign divisor     = MidLevel - {1'b0, center_ff};
   assign clamp       = num_full >= {divisor, {QuotWidth{1'b0}}};
   assign quot_pos    = $signed({1'b0, div_rsp.quotient});

   assign div_req.start    = (state_ff == StMap) && !in_center && !in_low_end
                             && !in_high_end && !clamp;
   assign div_req.dividend = num_full[NumWidth-1:0];
   assign div_req.divisor  = divisor;

   jafd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      alpha_in     = alpha_ff;
      center_in    = center_ff;
      end_in       = end_ff;
      filt_in      = filt_ff;
      sample_in    = sample_ff;
      positive_in  = positive_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pos_in   = rsp_pos_ff;
      rsp_level_in = rsp_level_ff;

      // Configuration writes; unknown indexes drop
      if (csr_wr_en) begin
         unique case (csr_index)
            CsrAlpha:  alpha_in  = csr_wdata[AlphaWidth-1:0];
            CsrCenter: center_in = csr_wdata;
            CsrEnd:    end_in    = csr_wdata;
            default:   ;
         endcase
      end

      unique case (state_ff)
         StIdle: begin
            if (req_xfer) begin
               sample_in = req_adc_sample;
               state_in  = StMul;
            end
         end
         StMul: begin
            state_in = StAcc;
         end
         StAcc: begin
            filt_in  = acc[StateWidth+FracBits-1:FracBits];
            state_in = StMap;
         end
         StMap: begin
            positive_in = positive;
            priority if (in_center) begin
               pos_in   = '0;
               state_in = StOut;
            end else if (in_low_end) begin
               pos_in   = -MaxOut;
               state_in = StOut;
            end else if (in_high_end || clamp) begin
               pos_in   = positive ? MaxOut : -MaxOut;
               state_in = StOut;
            end else begin
               state_in = StDiv;
            end
         end
         StDiv: begin
            if (div_rsp.done) begin
               pos_in   = positive_ff ? quot_pos : -quot_pos;
               state_in = StOut;
            end
         end
         StOut: begin
            // Hold until the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = pos_ff;
               rsp_level_in = level;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         alpha_ff     <= AlphaReset;
         center_ff    <= DeadzoneReset;
         end_ff       <= DeadzoneReset;
         filt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alpha_ff     <= alpha_in;
         center_ff    <= center_in;
         end_ff       <= end_in;
         filt_ff      <= filt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff    <= sample_in;
      prod_ff      <= prod_in;
      positive_ff  <= positive_in;
      pos_ff       <= pos_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_level_ff <= rsp_level_in;
   end

   assign req_stall          = state_ff != StIdle;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_axis_position  = rsp_pos_ff;
   assign rsp_smoothed_level = rsp_level_ff;

endmodule

`default_nettype wire

/* src/jafd_checker.sv */
// Port-level checker for the joystick axis filter, bound to the top level.
`default_nettype none

module jafd_checker (
   input wire                                  clock,
   input wire                                  reset,
   input wire                                  req_valid,
   input wire                                  req_stall,
   input wire                                  rsp_valid,
   input wire                                  rsp_stall,
   input wire signed [jafd_pkg::PosWidth-1:0]  rsp_axis_position,
   input wire [jafd_pkg::SampleWidth-1:0]      rsp_smoothed_level
);
   import jafd_pkg::*;

   // Block is busy right after taking an item
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after a transfer");

   // A transfer cannot come back as a result in the following cycle
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_valid) |=> !rsp_valid)
      else $error("result appeared one cycle after an input transfer");

   // Position stays within -255..255
   a_position_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_axis_position != -$signed({1'b0, MaxOut}) - 9'sd1))
      else $error("position out of range");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_axis_position)
                                    && $stable(rsp_smoothed_level)))
      else $error("stalled result changed");

   // Reset leaves the block idle and empty
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("block not idle after reset");

endmodule

bind joystick_axis_filter_deadzone_unit jafd_checker u_jafd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_axis_position  (rsp_axis_position),
   .rsp_smoothed_level (rsp_smoothed_level)
);

`default_nettype wire
